// ===== rtl/rxs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rxs_pkg;

  localparam int RECORDS_DEFAULT = 8;
  localparam int QDEPTH          = 2;
  localparam int QAW             = 1;
  localparam int TAG_W           = 8;
  localparam int TOTAL_W         = 10;
  localparam int AVG_W           = 8;
  localparam int REC_W           = TAG_W + TOTAL_W;

  // reciprocal of 3 in Q11, exact for totals below 2048
  localparam int RECIP3          = 683;
  localparam int RECIP3_SHIFT    = 11;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_SORT  = 2'd2
  } action_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [TOTAL_W-1:0] total;
  } rec_t;

  typedef struct packed {
    action_t act;
    rec_t    rec;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDI,
    ST_LDI,
    ST_CMP,
    ST_WRI,
    ST_ERD,
    ST_EOUT
  } state_t;

  function automatic logic [AVG_W-1:0] avg_of(input logic [TOTAL_W-1:0] total);
    logic [2*TOTAL_W-1:0] prod;
    prod = (2*TOTAL_W)'(total) * (2*TOTAL_W)'(RECIP3);
    return prod[RECIP3_SHIFT +: AVG_W];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rxs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rxs_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rxs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rxs_front (
  input  wire logic          s_tvalid,
  output      logic          s_tready,
  input  wire logic [31:0]   s_tdata,   // tag, mark_first, mark_second, mark_third
  input  wire logic [1:0]    s_tuser,   // action
  input  wire logic          q_full,
  output      logic          push,
  output      rxs_pkg::cmd_t cmd
);
  import rxs_pkg::*;

  logic known;

  assign s_tready = !q_full;

  always_comb begin
    unique case (s_tuser)
      ACT_CLEAR, ACT_LOAD, ACT_SORT: known = 1'b1;
      default:                       known = 1'b0;
    endcase
  end

  // unused action codes are taken and dropped here
  assign push = s_tvalid && s_tready && known;

  assign cmd.act       = action_t'(s_tuser);
  assign cmd.rec.tag   = s_tdata[7:0];
  assign cmd.rec.total = TOTAL_W'(s_tdata[15:8]) + TOTAL_W'(s_tdata[23:16])
                       + TOTAL_W'(s_tdata[31:24]);

endmodule
`default_nettype wire

// ===== rtl/rxs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rxs_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rxs_pkg::cmd_t push_cmd,
  output      logic          full,
  input  wire logic          pop,
  output      logic          valid,
  output      rxs_pkg::cmd_t head
);
  import rxs_pkg::*;

  cmd_t            slots [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    fill;

  assign full  = (fill == (QAW+1)'(QDEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (QAW+1)'(push) - (QAW+1)'(pop && valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rxs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rxs_back #(
  parameter int RECORDS = rxs_pkg::RECORDS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sort_key,
  input  wire logic                           q_valid,
  input  wire rxs_pkg::cmd_t                  q_head,
  output      logic                           q_pop,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      rxs_pkg::rec_t                  out_rec,
  output      logic [rxs_pkg::AVG_W-1:0]      out_avg,
  output      logic                           out_last,
  output      logic                           busy,
  output      logic [$clog2(RECORDS+1)-1:0]   count
);
  import rxs_pkg::*;

  localparam int CW = $clog2(RECORDS + 1);
  localparam int AW = $clog2(RECORDS);

  state_t          state, state_next;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   i, i_next, i_inc;
  logic [CW-1:0]   j, j_next, j_inc;
  logic [CW-1:0]   k, k_next, k_inc;
  rec_t            cur, cur_next;
  logic            out_valid_next;
  logic            out_load;

  logic            we;
  logic [AW-1:0]   waddr;
  rec_t            wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  rec_t            rdata;

  function automatic logic [TOTAL_W-1:0] key_of(input rec_t r, input logic by_avg);
    return by_avg ? TOTAL_W'(avg_of(r.total)) : r.total;
  endfunction

  rxs_ram #(
    .WIDTH (REC_W),
    .DEPTH (RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign i_inc = i + CW'(1);
  assign j_inc = j + CW'(1);
  assign k_inc = k + CW'(1);
  assign busy  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    cur <= cur_next;
    if (out_load) begin
      out_rec  <= rdata;
      out_avg  <= avg_of(rdata.total);
      out_last <= (k_inc == count);
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    cur_next       = cur;
    q_pop          = 1'b0;
    we             = 1'b0;
    waddr          = i[AW-1:0];
    wdata          = cur;
    re             = 1'b0;
    raddr          = i[AW-1:0];
    out_load       = 1'b0;
    out_valid_next = out_valid && !out_ready;

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.act)
            ACT_CLEAR: count_next = '0;
            ACT_LOAD: begin
              if (count < CW'(RECORDS)) begin
                we         = 1'b1;
                waddr      = count[AW-1:0];
                wdata      = q_head.rec;
                count_next = count + CW'(1);
              end
            end
            ACT_SORT: begin
              if (count != '0) begin
                i_next     = '0;
                state_next = ST_RDI;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RDI: begin
        re         = 1'b1;
        state_next = ST_LDI;
      end
      ST_LDI: begin
        cur_next = rdata;
        j_next   = i_inc;
        if (i_inc < count) begin
          re         = 1'b1;
          raddr      = i_inc[AW-1:0];
          state_next = ST_CMP;
        end else begin
          k_next     = '0;
          state_next = ST_ERD;
        end
      end
      ST_CMP: begin
        // cur holds entry i; a swap parks it at j and takes entry j
        if (key_of(cur, sort_key) > key_of(rdata, sort_key)) begin
          we       = 1'b1;
          waddr    = j[AW-1:0];
          wdata    = cur;
          cur_next = rdata;
        end
        if (j_inc < count) begin
          re         = 1'b1;
          raddr      = j_inc[AW-1:0];
          j_next     = j_inc;
        end else begin
          state_next = ST_WRI;
        end
      end
      ST_WRI: begin
        we         = 1'b1;
        waddr      = i[AW-1:0];
        wdata      = cur;
        i_next     = i_inc;
        state_next = ST_RDI;
      end
      ST_ERD: begin
        re         = 1'b1;
        raddr      = k[AW-1:0];
        state_next = ST_EOUT;
      end
      ST_EOUT: begin
        if (!out_valid || out_ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          if (k_inc == count) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k_inc;
            state_next = ST_ERD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/record_exchange_sort_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     tuser action, tdata tag and three marks
// m_*       out  m_tvalid / m_tready     tdata tag, total, average; tlast last record
// apb       in   psel, penable, pwrite   reg 0 at byte 0: sort_key
//
// Clear and load are done in the back end's idle state as they are popped from the queue.
// A sort of n records runs an exchange sort on the store (one read and one write port),
// then emits the records in order, holding while m_tready is low.
// The two-entry command queue takes up to two items while a sort runs;
// s_tready then stays low until the back end pops the next one.
// Reset empties the store count, the queue and the output register; sort_key to 0.
module record_exchange_sort_core #(
  parameter int RECORDS = rxs_pkg::RECORDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // tag, mark_first, mark_second, mark_third
  input  wire logic [1:0]  s_tuser,   // action
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // out_tag, out_total, out_average, zero pad
  output      logic        m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import rxs_pkg::*;

  localparam int CW = $clog2(RECORDS + 1);

  logic            sort_key;
  logic            q_full;
  logic            push;
  cmd_t            push_cmd;
  logic            q_valid;
  cmd_t            q_head;
  logic            q_pop;
  rec_t            out_rec;
  logic [AVG_W-1:0] out_avg;
  logic            busy;
  logic [CW-1:0]   count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, sort_key} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      sort_key <= pwdata[0];
    end
  end

  rxs_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  rxs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  rxs_back #(
    .RECORDS (RECORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .sort_key  (sort_key),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec),
    .out_avg   (out_avg),
    .out_last  (m_tlast),
    .busy      (busy),
    .count     (count)
  );

  assign m_tdata = {6'd0, out_avg, out_rec.total, out_rec.tag};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(RECORDS))
    else $error("record count above capacity");

  a_emit_from_sort: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(busy))
    else $error("result raised outside a sort");

  a_sort_needs_records: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(count) != '0)
    else $error("sort started on an empty store");
`endif

endmodule
`default_nettype wire
